FILE: design/wpef_pkg.sv
package wpef_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int DIV_STEPS = 16;
	localparam int GAIN_ONE  = 32767;
	localparam int MIN_FILE  = 64;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_HDR,
		PH_BODY,
		PH_LO,
		PH_HI,
		PH_PASS
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_MUL,
		ST_SCALE,
		ST_EMIT_LO,
		ST_EMIT_HI
	} state_t;

endpackage

FILE: design/wav_pcm16_edge_fade.sv
// Linear edge fade for 16-bit PCM RIFF/WAVE files, fed one file byte per word.
// Input channel: data_byte plus file_size (same on every byte of a file),
// in_valid/in_ready. Output channel: out_byte, run_last, file_end,
// out_valid/out_ready.
// Header bytes and bytes outside the faded region pass through: one output
// word per input word, loaded into the output register that drives out_valid.
// Inside the data chunk the low byte of a sample is held and gives no word;
// the high byte gives two words (low byte, then high byte, run_last on the
// second). A sample in the fade window goes through one shared bit-serial
// divider twice (gain = pos*32767/F, then s*gain/32767, 16 steps each) with
// one multiply between: the low output word is loaded after the second
// divide, and the next byte is taken only once both words of the pair have
// been loaded into the output register. An unfaded pair skips the divider.
// One word is worked on at a time. The output register lets the next byte be
// taken while the last word waits; while out_ready is low the output word
// holds and in_ready drops once that register is full.
// Reset clears the parser to the start of a file. After the final byte of a
// file (byte offset + 1 >= file_size) the parser restarts for the next file.
module wav_pcm16_edge_fade #(
	parameter int MAX_FILE_BYTES = 1048576,
	parameter int FADE_MAX       = 256,
	parameter int SHORT_LIMIT    = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [23:0] file_size,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        file_end
);
	import wpef_pkg::*;

	localparam int SHORT_FADE = (SHORT_LIMIT - 1) / 8;
	localparam int FADE_TOP   = (FADE_MAX > SHORT_FADE) ? FADE_MAX : SHORT_FADE;
	localparam int FADE_W     = $clog2(FADE_TOP + 1);
	localparam int DW         = (FADE_W > 15) ? FADE_W : 15;
	localparam int NW         = DW + 16;

	// parser state
	logic [23:0]       off_q, off_n;
	phase_t            phase_q, phase_n;
	logic              hok_q, hok_n;
	logic [31:0]       cid_q, cid_n;
	logic [31:0]       clen_q, clen_n;
	logic [23:0]       nco_q, nco_n;
	logic [15:0]       fmt_q, fmt_n;
	logic [15:0]       bits_q, bits_n;
	logic [22:0]       total_q, total_n;
	logic [FADE_W-1:0] fade_q, fade_n;
	logic [22:0]       sidx_q, sidx_n;
	logic [7:0]        held_q, held_n;

	// sample work context
	state_t            st_q, st_n;
	logic [15:0]       mag_q;
	logic              neg_q;
	logic              fin_q;
	logic [14:0]       gain_q;
	logic [15:0]       res_q;

	// output register
	logic              ov_q;
	logic [7:0]        ob_q;
	logic              rl_q;
	logic              fe_q;

	logic              fin;
	phase_t            ph;
	logic [31:0]       cid_sh, clen_sh;
	logic [23:0]       hpos;
	logic [24:0]       body;
	logic [32:0]       chunk_end, nxt;
	logic [30:0]       tot_w;
	logic [FADE_W-1:0] fade_w;
	logic [31:0]       rel;
	logic              emit1, hi_go, hi_pass;
	logic [15:0]       raw;
	logic [FADE_W-1:0] pos;
	logic              slot_free, acc;
	logic              div_start, div_done;
	logic [NW-1:0]     div_num;
	logic [DW-1:0]     div_den;
	logic [15:0]       div_quo;
	logic [31:0]       prod;
	logic [15:0]       scaled;
	logic              out_load;
	logic [7:0]        load_byte;
	logic              load_last, load_fin;

	assign slot_free = !ov_q || out_ready;
	assign acc       = in_valid && in_ready;
	assign raw       = {data_byte, held_q};

	// parse one byte
	always_comb begin
		fin     = ({1'b0, off_q} + 25'd1) >= {1'b0, file_size};
		ph      = (phase_q == PH_BODY && off_q == nco_q) ? PH_HDR : phase_q;
		cid_sh  = {data_byte, cid_q[31:8]};
		clen_sh = {data_byte, clen_q[31:8]};
		hpos    = off_q - nco_q;
		body    = {1'b0, off_q} + 25'd1;
		phase_n = ph;
		hok_n   = hok_q;
		cid_n   = cid_q;
		clen_n  = clen_q;
		nco_n   = nco_q;
		fmt_n   = fmt_q;
		bits_n  = bits_q;
		total_n = total_q;
		fade_n  = fade_q;
		sidx_n  = sidx_q;
		held_n  = held_q;
		emit1   = 1'b1;
		hi_go   = 1'b0;
		hi_pass = 1'b0;
		pos     = '0;
		chunk_end = '0;
		nxt     = '0;
		tot_w   = '0;
		fade_w  = '0;
		rel     = '0;
		unique case (ph)
			PH_RIFF: begin
				cid_n = cid_sh;
				if (off_q == 24'd3)
					hok_n = (cid_sh == TAG_RIFF);
				if (off_q >= 24'd11) begin
					if (hok_q && cid_sh == TAG_WAVE && file_size >= 24'(MIN_FILE)
							&& {1'b0, file_size} <= 25'(MAX_FILE_BYTES))
						phase_n = PH_HDR;
					else
						phase_n = PH_PASS;
				end
			end
			PH_HDR: begin
				if (hpos < 24'd4)
					cid_n = cid_sh;
				else
					clen_n = clen_sh;
				if (hpos >= 24'd7) begin
					chunk_end = {8'd0, body} + {1'b0, clen_n};
					nxt       = chunk_end + {32'd0, clen_n[0]};
					tot_w     = clen_n[31:1];
					fade_w    = (tot_w < 31'(SHORT_LIMIT)) ? FADE_W'(tot_w >> 3)
						: FADE_W'(FADE_MAX);
					if (chunk_end > {9'd0, file_size}) begin
						phase_n = PH_PASS;
					end else if (cid_n == TAG_DATA) begin
						if (fmt_q != 16'd1 || bits_q != 16'd16 || clen_n < 32'd8) begin
							phase_n = PH_PASS;
						end else begin
							total_n = tot_w[22:0];
							fade_n  = fade_w;
							if (fade_w >= FADE_W'(4) && 31'({fade_w, 1'b0}) < tot_w) begin
								sidx_n  = '0;
								phase_n = PH_LO;
							end else begin
								phase_n = PH_PASS;
							end
						end
					end else if (nxt + 33'd8 > {9'd0, file_size}) begin
						phase_n = PH_PASS;
					end else begin
						nco_n   = nxt[23:0];
						phase_n = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (cid_q == TAG_FMT && clen_q >= 32'd16) begin
					rel = 32'(off_q) - 32'(nco_q) + clen_q + {31'd0, clen_q[0]};
					case (rel)
						32'd0:  fmt_n  = {fmt_q[15:8], data_byte};
						32'd1:  fmt_n  = {data_byte, fmt_q[7:0]};
						32'd14: bits_n = {bits_q[15:8], data_byte};
						32'd15: bits_n = {data_byte, bits_q[7:0]};
						default: ;
					endcase
				end
			end
			PH_LO: begin
				if (!fin) begin
					held_n  = data_byte;
					phase_n = PH_HI;
					emit1   = 1'b0;
				end
			end
			PH_HI: begin
				emit1   = 1'b0;
				sidx_n  = sidx_q + 23'd1;
				phase_n = (sidx_n >= total_q) ? PH_PASS : PH_LO;
				if (sidx_q < 23'(fade_q)) begin
					pos   = FADE_W'(sidx_q);
					hi_go = 1'b1;
				end else if (sidx_q >= total_q - 23'(fade_q)) begin
					pos   = FADE_W'(total_q - 23'd1 - sidx_q);
					hi_go = 1'b1;
				end else begin
					hi_pass = 1'b1;
				end
			end
			PH_PASS: ;
			default: ;
		endcase
		off_n = off_q + 24'd1;
		if (fin) begin
			off_n   = '0;
			phase_n = PH_RIFF;
			hok_n   = 1'b0;
			cid_n   = '0;
			clen_n  = '0;
			nco_n   = 24'd12;
			fmt_n   = '0;
			bits_n  = '0;
			total_n = '0;
			fade_n  = '0;
			sidx_n  = '0;
			held_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			phase_q <= PH_RIFF;
			hok_q   <= 1'b0;
			cid_q   <= '0;
			clen_q  <= '0;
			nco_q   <= 24'd12;
			fmt_q   <= '0;
			bits_q  <= '0;
			total_q <= '0;
			fade_q  <= '0;
			sidx_q  <= '0;
			held_q  <= '0;
		end else if (acc) begin
			off_q   <= off_n;
			phase_q <= phase_n;
			hok_q   <= hok_n;
			cid_q   <= cid_n;
			clen_q  <= clen_n;
			nco_q   <= nco_n;
			fmt_q   <= fmt_n;
			bits_q  <= bits_n;
			total_q <= total_n;
			fade_q  <= fade_n;
			sidx_q  <= sidx_n;
			held_q  <= held_n;
		end
	end

	// sequencer next state
	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (acc && hi_go)
					st_n = ST_GAIN;
				else if (acc && hi_pass)
					st_n = ST_EMIT_LO;
			end
			ST_GAIN:    if (div_done) st_n = ST_MUL;
			ST_MUL:     st_n = ST_SCALE;
			ST_SCALE:   if (div_done) st_n = ST_EMIT_LO;
			ST_EMIT_LO: if (slot_free) st_n = ST_EMIT_HI;
			ST_EMIT_HI: if (slot_free) st_n = ST_IDLE;
			default:    st_n = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		load_byte = data_byte;
		load_last = 1'b1;
		load_fin  = fin;
		unique case (st_q)
			ST_IDLE: begin
				in_ready  = slot_free;
				div_start = acc && hi_go;
				out_load  = acc && emit1;
			end
			ST_GAIN, ST_SCALE: ;
			ST_MUL:   div_start = 1'b1;
			ST_EMIT_LO: begin
				out_load  = slot_free;
				load_byte = res_q[7:0];
				load_last = 1'b0;
				load_fin  = fin_q;
			end
			ST_EMIT_HI: begin
				out_load  = slot_free;
				load_byte = res_q[15:8];
				load_fin  = fin_q;
			end
			default: ;
		endcase
	end

	// first pass divides pos*32767 by the fade length, second divides by 32767
	assign prod    = 32'(mag_q) * 32'(gain_q);
	assign div_num = (st_q == ST_MUL) ? NW'(prod)
		: ((NW'(pos) << 15) - NW'(pos));
	assign div_den = (st_q == ST_MUL) ? DW'(GAIN_ONE) : DW'(fade_q);
	assign scaled  = neg_q ? (16'd0 - div_quo) : div_quo;

	wpef_sdiv #(.NW(NW), .DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_n;
	end

	// hold the sample context while the divider runs
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && acc && (hi_go || hi_pass)) begin
			fin_q <= fin;
			neg_q <= raw[15];
			mag_q <= raw[15] ? (16'd0 - raw) : raw;
			res_q <= raw;
		end
		if (st_q == ST_GAIN && div_done)
			gain_q <= div_quo[14:0];
		if (st_q == ST_SCALE && div_done)
			res_q <= scaled;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (out_load)
			ov_q <= 1'b1;
		else if (out_ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ob_q <= load_byte;
			rl_q <= load_last;
			fe_q <= load_fin;
		end
	end

	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign run_last  = rl_q;
	assign file_end  = fe_q;

endmodule

FILE: design/wpef_sdiv.sv
module wpef_sdiv #(
	parameter int NW = 31,
	parameter int DW = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [15:0]   quo
);
	import wpef_pkg::*;

	logic [DW-1:0] rem_q;
	logic [15:0]   num_q;
	logic [DW-1:0] den_q;
	logic [15:0]   quo_q;
	logic [3:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fit;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, num_q[15]};
	assign fit   = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NW-1:16];
			num_q <= num[15:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			num_q <= {num_q[14:0], 1'b0};
			quo_q <= {quo_q[14:0], fit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: design/wpef_chk.sv
module wpef_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        run_last,
	input logic        file_end
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("output word changed while stalled");

	// the high byte of a pair follows its low byte at once, same file_end
	a_pair_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid && run_last
			&& file_end == $past(file_end))
		else $error("second word of a pair missing");

	// no byte taken while half a pair is pending
	a_pair_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !in_ready)
		else $error("input taken during a pair");

endmodule

bind wav_pcm16_edge_fade wpef_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.run_last  (run_last),
	.file_end  (file_end)
);

FILE: verif/testbench.sv
module testbench;
	import wpef_pkg::*;

	localparam int MAX_FILE  = 1048576;
	localparam int FADE_CAP  = 256;
	localparam int SHORT_LIM = 512;
	localparam int IDLE_PCT  = 37;
	localparam int STALL_LIM = 20000;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [23:0] file_size;
	} file_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       file_end;
	} fade_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic [23:0] file_size;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        run_last;
	logic        file_end;

	wav_pcm16_edge_fade i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.file_size (file_size),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.file_end  (file_end)
	);

	// Words waiting for the driver, and words the block still owes us.
	file_word_t pending_bytes[$];
	fade_word_t faded_words[$];
	int         fail_count;
	bit         pause_req;    // sender holds while this is set
	bit         hold_req;     // receiver holds off for a long stretch
	bit         calm;         // no random idling on either side

	// Parser state of the predictor.
	logic [23:0] p_offset;
	phase_t      p_phase;
	logic        p_hdr_ok;
	logic [31:0] p_id;
	logic [31:0] p_len;
	logic [23:0] p_next;
	logic [15:0] p_fmt;
	logic [15:0] p_bits;
	logic [22:0] p_total;
	logic [8:0]  p_fade;
	logic [22:0] p_index;
	logic [7:0]  p_low;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic restart_parser();
		p_offset = '0;
		p_phase  = PH_RIFF;
		p_hdr_ok = 1'b0;
		p_id     = '0;
		p_len    = '0;
		p_next   = 24'd12;
		p_fmt    = '0;
		p_bits   = '0;
		p_total  = '0;
		p_fade   = '0;
		p_index  = '0;
		p_low    = '0;
	endtask

	// Close a chunk header: decide between data, skip to next chunk, or bail out.
	task automatic close_chunk_header(input logic [23:0] fsz);
		longint body;
		longint len;
		longint nxt;
		longint total;
		longint fade;
		body = longint'(p_offset) + 1;
		len  = longint'(p_len);
		if (body + len > fsz) begin
			p_phase = PH_PASS;
			return;
		end
		if (p_id == TAG_DATA) begin
			if (p_fmt != 16'd1 || p_bits != 16'd16 || p_len < 32'd8) begin
				p_phase = PH_PASS;
				return;
			end
			total   = len / 2;
			fade    = (total < SHORT_LIM) ? total / 8 : FADE_CAP;
			p_total = total[22:0];
			p_fade  = fade[8:0];
			if (fade >= 4 && 2 * fade < total) begin
				p_index = '0;
				p_phase = PH_LO;
			end else begin
				p_phase = PH_PASS;
			end
			return;
		end
		nxt = body + len + (len & 1);
		if (nxt + 8 > fsz) begin
			p_phase = PH_PASS;
			return;
		end
		p_next  = nxt[23:0];
		p_phase = PH_BODY;
	endtask

	function automatic logic [15:0] scale_sample(logic [15:0] raw);
		int          s;
		longint      pos;
		longint      gain;
		longint      r;
		s = $signed(raw);
		if (p_index < p_fade)
			pos = p_index;
		else if (p_index >= p_total - p_fade)
			pos = p_total - 1 - p_index;
		else
			return raw;
		gain = (pos * 32767) / p_fade;
		r = (longint'(s) * gain) / 32767;
		return r[15:0];
	endfunction

	// Advance the predictor by one input word and queue the words it causes.
	task automatic predict_fade(input file_word_t w);
		logic        fin;
		int          n;
		logic [7:0]  first;
		logic [7:0]  second;
		logic [15:0] v;
		logic [23:0] rel;
		logic [31:0] start;
		fin    = (longint'(p_offset) + 1 >= w.file_size);
		n      = 1;
		first  = w.data_byte;
		second = '0;
		if (p_phase == PH_BODY && p_offset == p_next)
			p_phase = PH_HDR;
		case (p_phase)
			PH_RIFF: begin
				p_id = {w.data_byte, p_id[31:8]};
				if (p_offset == 24'd3)
					p_hdr_ok = (p_id == TAG_RIFF);
				if (p_offset >= 24'd11) begin
					if (p_hdr_ok && p_id == TAG_WAVE && w.file_size >= MIN_FILE
							&& w.file_size <= MAX_FILE)
						p_phase = PH_HDR;
					else
						p_phase = PH_PASS;
				end
			end
			PH_HDR: begin
				rel = p_offset - p_next;
				if (rel < 4)
					p_id = {w.data_byte, p_id[31:8]};
				else
					p_len = {w.data_byte, p_len[31:8]};
				if (rel >= 7)
					close_chunk_header(w.file_size);
			end
			PH_BODY: begin
				if (p_id == TAG_FMT && p_len >= 32'd16) begin
					start = 32'(p_next) - p_len - (p_len & 32'd1);
					rel   = 24'(32'(p_offset) - start);
					if (rel == 0)       p_fmt[7:0]   = w.data_byte;
					else if (rel == 1)  p_fmt[15:8]  = w.data_byte;
					else if (rel == 14) p_bits[7:0]  = w.data_byte;
					else if (rel == 15) p_bits[15:8] = w.data_byte;
				end
			end
			PH_LO: begin
				if (!fin) begin
					p_low   = w.data_byte;
					p_phase = PH_HI;
					n       = 0;
				end
			end
			PH_HI: begin
				v       = scale_sample({w.data_byte, p_low});
				first   = v[7:0];
				second  = v[15:8];
				n       = 2;
				p_index = p_index + 1'b1;
				p_phase = (p_index >= p_total) ? PH_PASS : PH_LO;
			end
			default: ;
		endcase
		if (n >= 1)
			faded_words.insert(faded_words.size(), fade_word_t'{first, n == 1, fin});
		if (n == 2)
			faded_words.insert(faded_words.size(), fade_word_t'{second, 1'b1, fin});
		p_offset = p_offset + 1'b1;
		if (fin)
			restart_parser();
	endtask

	task automatic report_mismatch(input string what, input fade_word_t got,
			input fade_word_t want);
		$display("mismatch %s: got byte %02h last %0b end %0b, want byte %02h last %0b end %0b",
			what, got.out_byte, got.run_last, got.file_end,
			want.out_byte, want.run_last, want.file_end);
		fail_count++;
	endtask

	// Stimulus helpers: build one WAV file as a byte list.
	task automatic push_file(input logic [7:0] bytes[$], input logic [23:0] fsz);
		foreach (bytes[i])
			pending_bytes.insert(pending_bytes.size(), file_word_t'{bytes[i], fsz});
	endtask

	task automatic put_le(inout logic [7:0] bytes[$], input logic [31:0] v, input int nb);
		for (int i = 0; i < nb; i++)
			bytes.insert(bytes.size(), v[8*i +: 8]);
	endtask

	// Build a file: RIFF header, optional junk chunk (any length, padded to even), fmt, data.
	// Flaws pick one broken field so rejected files show up too.
	task automatic make_wav(input int samples, input int junk_len, input int flaw,
			input int extra_data);
		logic [7:0] f[$];
		int         dlen;
		int         total;
		dlen  = samples * 2 + extra_data;
		total = 12 + (junk_len >= 0 ? 8 + junk_len + (junk_len & 1) : 0) + 24 + 8 + dlen;
		put_le(f, (flaw == 1) ? 32'h4646_4953 : TAG_RIFF, 4);
		put_le(f, total - 8, 4);
		put_le(f, (flaw == 2) ? 32'h4556_4158 : TAG_WAVE, 4);
		if (junk_len >= 0) begin
			put_le(f, 32'h6B6E_756A, 4);
			put_le(f, junk_len, 4);
			for (int i = 0; i < junk_len + (junk_len & 1); i++)
				f.insert(f.size(), 8'($urandom_range(0, 255)));
		end
		put_le(f, TAG_FMT, 4);
		put_le(f, 16, 4);
		put_le(f, (flaw == 3) ? 3 : 1, 2);
		put_le(f, $urandom_range(1, 2), 2);
		put_le(f, $urandom, 4);
		put_le(f, $urandom, 4);
		put_le(f, 4, 2);
		put_le(f, (flaw == 4) ? 8 : 16, 2);
		put_le(f, TAG_DATA, 4);
		put_le(f, (flaw == 5) ? dlen + 100 : dlen, 4);
		for (int i = 0; i < dlen; i++) begin
			case ($urandom_range(0, 5))
				0: f.insert(f.size(), 8'h00);
				1: f.insert(f.size(), 8'hFF);
				2: f.insert(f.size(), (i & 1) ? 8'h80 : 8'h00);
				3: f.insert(f.size(), (i & 1) ? 8'h7F : 8'hFF);
				default: f.insert(f.size(), 8'($urandom_range(0, 255)));
			endcase
		end
		push_file(f, (flaw == 6) ? f.size() + $urandom_range(0, 3) : f.size());
	endtask

	// Driver: hold the word until accepted, idle at random otherwise.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			data_byte <= '0;
			file_size <= '0;
		end else begin
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() != 0 && !pause_req
						&& (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					data_byte <= pending_bytes[0].data_byte;
					file_size <= pending_bytes[0].file_size;
					in_valid  <= 1'b1;
					void'(pending_bytes.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Predict at the accepting edge, from the values the block saw.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			predict_fade('{data_byte, file_size});
	end

	// Monitor: compare each accepted word against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (faded_words.size() == 0)
					report_mismatch("unexpected word", '{out_byte, run_last, file_end}, '0);
				else if ({out_byte, run_last, file_end} != faded_words[0]) begin
					report_mismatch("field", '{out_byte, run_last, file_end}, faded_words[0]);
					void'(faded_words.pop_front());
				end else
					void'(faded_words.pop_front());
			end
			out_ready <= !hold_req && (calm || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Watchdog: count cycles with no handshake on either side.
	int quiet_cycles;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n || hold_req
				|| pause_req)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIM) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid || faded_words.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int         sent;
		fail_count = 0;
		pause_req  = 1'b0;
		hold_req   = 1'b0;
		calm       = 1'b0;
		in_valid   = 1'b0;
		out_ready  = 1'b0;
		data_byte  = '0;
		file_size  = '0;
		restart_parser();
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero size passes through, tiny bad file, extreme bytes.
		pending_bytes.insert(pending_bytes.size(), file_word_t'{8'h00, 24'd0});
		pending_bytes.insert(pending_bytes.size(), file_word_t'{8'hFF, 24'hFFFFFF});
		pending_bytes.insert(pending_bytes.size(), file_word_t'{8'hA5, 24'd1});
		for (int i = 0; i < 4; i++)
			pending_bytes.insert(pending_bytes.size(), file_word_t'{8'(i * 85), 24'd4});
		// Short fadable data: 33 samples gives fade 4, plus an odd tail byte.
		make_wav(33, -1, 0, 1);
		wait_drained();

		// With everything back, pause the sender and release it again.
		pause_req = 1'b1;
		repeat (5) @(posedge clk);
		pause_req = 1'b0;

		// Long receiver hold-off while the sender keeps offering.
		make_wav(40, 3, 0, 0);
		hold_req = 1'b1;
		repeat (300) @(posedge clk);
		hold_req = 1'b0;
		wait_drained();

		// Random files: mostly valid with random content, some broken.
		sent = 0;
		while (sent < 1600) begin
			int samples;
			int flaw;
			samples = ($urandom_range(0, 19) == 0 && sent < 1000) ? $urandom_range(512, 560)
				: $urandom_range(4, 90);
			flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
			calm = (sent > 900 && sent < 1300);
			make_wav(samples, ($urandom_range(0, 1) != 0) ? $urandom_range(0, 5) : -1,
				flaw, $urandom_range(0, 1));
			sent += pending_bytes.size();
			wait_drained();
		end
		// Noise bytes with random sizes.
		for (int i = 0; i < 40; i++)
			pending_bytes.insert(pending_bytes.size(),
				file_word_t'{8'($urandom), 24'($urandom_range(0, 70))});
		wait_drained();

		repeat (100) @(posedge clk);
		if (fail_count == 0 && faded_words.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
